// ----- rtl/gbc_pkg.sv -----
`default_nettype none
package gbc_pkg;

  // payload widths
  localparam int SCORE_W  = 17;
  localparam int SIZE_W   = 5;
  localparam int OIDX_W   = 4;
  localparam int TIE_W    = 9;
  localparam int NSUM_W   = 19;
  localparam int NCNT_W   = 3;
  localparam int PROD_W   = NSUM_W + NCNT_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GAMMA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_C     = 1'd1;

  // reset sizes
  localparam logic [SIZE_W-1:0] NUM_GAMMA_RST = 5'd10;
  localparam logic [SIZE_W-1:0] NUM_C_RST     = 5'd11;

  // control from the sequencer to the tie ranking unit
  typedef struct packed {
    logic init;
    logic clear;
    logic acc;
    logic cmp;
  } rank_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/gbc_if.sv -----
`default_nettype none
interface gbc_in_if;
  import gbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  modport source (output valid, output score, input ready);
  modport sink (input valid, input score, output ready);
endinterface

interface gbc_out_if;
  import gbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [OIDX_W-1:0]  best_row;
  logic [OIDX_W-1:0]  best_col;
  logic [SCORE_W-1:0] best_score;
  logic [TIE_W-1:0]   tie_count;
  modport source (output valid, output best_row, output best_col, output best_score,
                  output tie_count, input ready);
  modport sink (input valid, input best_row, input best_col, input best_score,
                input tie_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/gbc_grid_mem.sv -----
`default_nettype none
module gbc_grid_mem #(
  parameter int DEPTH  = 256,
  parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DW     = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gbc_rank.sv -----
`default_nettype none
module gbc_rank (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire gbc_pkg::rank_ctl_t         ctl,
  input  wire logic [gbc_pkg::SCORE_W-1:0] rd_data,
  output logic                            take
);
  import gbc_pkg::*;

  logic [NSUM_W-1:0] cand_sum_r, cand_sum_nxt;
  logic [NCNT_W-1:0] cand_cnt_r, cand_cnt_nxt;
  logic [NSUM_W-1:0] best_sum_r, best_sum_nxt;
  logic [NCNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic              have_r, have_nxt;
  logic [PROD_W-1:0] lhs, rhs;

  // exact mean compare by cross-multiplication
  assign lhs  = PROD_W'(cand_sum_r) * PROD_W'(best_cnt_r);
  assign rhs  = PROD_W'(best_sum_r) * PROD_W'(cand_cnt_r);
  assign take = !have_r || (lhs > rhs) || ((lhs == rhs) && (cand_cnt_r >= best_cnt_r));

  // candidate accumulation and best update
  always_comb begin
    cand_sum_nxt = cand_sum_r;
    cand_cnt_nxt = cand_cnt_r;
    best_sum_nxt = best_sum_r;
    best_cnt_nxt = best_cnt_r;
    have_nxt     = have_r;
    if (ctl.init) begin
      have_nxt = 1'b0;
    end
    if (ctl.clear) begin
      cand_sum_nxt = '0;
      cand_cnt_nxt = '0;
    end else if (ctl.acc) begin
      cand_sum_nxt = cand_sum_r + NSUM_W'(rd_data);
      cand_cnt_nxt = cand_cnt_r + NCNT_W'(1);
    end
    if (ctl.cmp && take) begin
      best_sum_nxt = cand_sum_r;
      best_cnt_nxt = cand_cnt_r;
      have_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
    cand_sum_r <= cand_sum_nxt;
    cand_cnt_r <= cand_cnt_nxt;
    best_sum_r <= best_sum_nxt;
    best_cnt_r <= best_cnt_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/grid_best_cell_with_neighbor_tiebreak.sv -----
// Best-cell picker over a grid of Q1.16 scores. Scores arrive one per transaction in
// row-major order (num_gamma rows by num_c columns, sizes clamped to 1..MAX_ROWS and
// 1..MAX_COLS, scores above 1.0 saturated) and are stored in a single-port-read grid
// memory. A cell is taken every cycle while loading. After the last cell of a grid the
// block does a max pass over the memory and a decision step, then, only if more than
// one cell holds the maximum, a tie pass in which each tied cell's up/down/left/right
// neighbours are read one at a time and their mean is compared exactly with the best
// so far. The result is then registered. One result (row, column, best score, tie
// count) follows per grid; loading of the next grid starts as soon as it is registered.
// Any configuration write restarts loading at the first cell.
`default_nettype none
module grid_best_cell_with_neighbor_tiebreak #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gbc_in_if.sink                             in_chan,
  gbc_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [gbc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [gbc_pkg::SIZE_W-1:0]    cfg_wdata
);
  import gbc_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RSZ_W = ROW_W + 1;
  localparam int CSZ_W = COL_W + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_MAX, S_MAX_END, S_DECIDE, S_T_SELF, S_T_CHK, S_T_NB, S_T_CMP, S_DONE
  } state_t;

  typedef enum logic [2:0] {NB_UP, NB_DOWN, NB_LEFT, NB_RIGHT, NB_END} nb_sel_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   num_gamma_r, num_gamma_nxt;
  logic [SIZE_W-1:0]   num_c_r, num_c_nxt;
  logic [CNT_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [ROW_W-1:0]    scan_row_r, scan_row_nxt;
  logic [COL_W-1:0]    scan_col_r, scan_col_nxt;
  logic                mx_v_r, mx_v_nxt;
  logic [ROW_W-1:0]    mx_row_r, mx_row_nxt;
  logic [COL_W-1:0]    mx_col_r, mx_col_nxt;
  logic [SCORE_W-1:0]  max_r, max_nxt;
  logic [CNT_W-1:0]    ties_r, ties_nxt;
  logic [ROW_W-1:0]    best_row_r, best_row_nxt;
  logic [COL_W-1:0]    best_col_r, best_col_nxt;
  nb_sel_t             nb_k_r, nb_k_nxt;
  logic                nb_pend_r, nb_pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OIDX_W-1:0]   out_row_r, out_row_nxt;
  logic [OIDX_W-1:0]   out_col_r, out_col_nxt;
  logic [SCORE_W-1:0]  out_score_r, out_score_nxt;
  logic [TIE_W-1:0]    out_ties_r, out_ties_nxt;

  logic [RSZ_W-1:0]    rows_c;
  logic [CSZ_W-1:0]    cols_c;
  logic [CNT_W-1:0]    total_c;
  logic [CNT_W-1:0]    ld_addr;
  logic [SCORE_W-1:0]  sat_score;
  logic                in_acc;
  logic                last_cell;
  logic                col_wrap;
  logic [IDX_W-1:0]    adv_idx;
  logic [ROW_W-1:0]    adv_row;
  logic [COL_W-1:0]    adv_col;
  logic                nb_exists;
  logic [IDX_W-1:0]    nb_addr;
  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic [SCORE_W-1:0]  rd_data;
  rank_ctl_t           rank_ctl;
  logic                rank_take;

  // grid size after clamping
  always_comb begin
    if (num_gamma_r == '0) begin
      rows_c = RSZ_W'(1);
    end else if (32'(num_gamma_r) > MAX_ROWS) begin
      rows_c = RSZ_W'(MAX_ROWS);
    end else begin
      rows_c = RSZ_W'(num_gamma_r);
    end
    if (num_c_r == '0) begin
      cols_c = CSZ_W'(1);
    end else if (32'(num_c_r) > MAX_COLS) begin
      cols_c = CSZ_W'(MAX_COLS);
    end else begin
      cols_c = CSZ_W'(num_c_r);
    end
  end

  assign total_c = CNT_W'(rows_c) * CNT_W'(cols_c);

  // load path
  assign in_chan.ready = (state_r == S_LOAD);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign sat_score     = (in_chan.score > SCORE_ONE) ? SCORE_ONE : in_chan.score;
  assign ld_addr       = (load_cnt_r >= total_c) ? '0 : load_cnt_r;
  assign mem_we        = in_acc;

  // scan position stepping
  assign last_cell = (CNT_W'(scan_idx_r) + CNT_W'(1)) == total_c;
  assign col_wrap  = (CSZ_W'(scan_col_r) + CSZ_W'(1)) == cols_c;
  assign adv_idx   = scan_idx_r + IDX_W'(1);
  assign adv_col   = col_wrap ? '0 : scan_col_r + COL_W'(1);
  assign adv_row   = col_wrap ? scan_row_r + ROW_W'(1) : scan_row_r;

  // neighbour selection for the tie pass
  always_comb begin
    case (nb_k_r)
      NB_UP: begin
        nb_exists = (scan_row_r != '0);
        nb_addr   = scan_idx_r - IDX_W'(cols_c);
      end
      NB_DOWN: begin
        nb_exists = (RSZ_W'(scan_row_r) + RSZ_W'(1)) < rows_c;
        nb_addr   = scan_idx_r + IDX_W'(cols_c);
      end
      NB_LEFT: begin
        nb_exists = (scan_col_r != '0);
        nb_addr   = scan_idx_r - IDX_W'(1);
      end
      NB_RIGHT: begin
        nb_exists = !col_wrap;
        nb_addr   = scan_idx_r + IDX_W'(1);
      end
      default: begin
        nb_exists = 1'b0;
        nb_addr   = scan_idx_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    num_gamma_nxt = num_gamma_r;
    num_c_nxt     = num_c_r;
    load_cnt_nxt  = load_cnt_r;
    scan_idx_nxt  = scan_idx_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    mx_v_nxt      = 1'b0;
    mx_row_nxt    = scan_row_r;
    mx_col_nxt    = scan_col_r;
    max_nxt       = max_r;
    ties_nxt      = ties_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    nb_k_nxt      = nb_k_r;
    nb_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_score_nxt = out_score_r;
    out_ties_nxt  = out_ties_r;
    mem_re        = 1'b0;
    mem_raddr     = scan_idx_r;
    rank_ctl      = '0;

    // max pass: fold the word read in the previous cycle
    if (mx_v_r) begin
      if (rd_data > max_r) begin
        max_nxt      = rd_data;
        ties_nxt     = CNT_W'(1);
        best_row_nxt = mx_row_r;
        best_col_nxt = mx_col_r;
      end else if (rd_data == max_r) begin
        ties_nxt = ties_r + CNT_W'(1);
      end
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if ((ld_addr + CNT_W'(1)) == total_c) begin
            load_cnt_nxt = '0;
            scan_idx_nxt = '0;
            scan_row_nxt = '0;
            scan_col_nxt = '0;
            max_nxt      = '0;
            ties_nxt     = '0;
            best_row_nxt = '0;
            best_col_nxt = '0;
            state_nxt    = S_MAX;
          end else begin
            load_cnt_nxt = ld_addr + CNT_W'(1);
          end
        end
      end
      S_MAX: begin
        mem_re   = 1'b1;
        mx_v_nxt = 1'b1;
        if (last_cell) begin
          state_nxt = S_MAX_END;
        end else begin
          scan_idx_nxt = adv_idx;
          scan_row_nxt = adv_row;
          scan_col_nxt = adv_col;
        end
      end
      S_MAX_END: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (ties_r > CNT_W'(1)) begin
          rank_ctl.init = 1'b1;
          scan_idx_nxt  = '0;
          scan_row_nxt  = '0;
          scan_col_nxt  = '0;
          state_nxt     = S_T_SELF;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_T_SELF: begin
        mem_re    = 1'b1;
        state_nxt = S_T_CHK;
      end
      S_T_CHK: begin
        if (rd_data == max_r) begin
          rank_ctl.clear = 1'b1;
          nb_k_nxt       = NB_UP;
          state_nxt      = S_T_NB;
        end else if (last_cell) begin
          state_nxt = S_DONE;
        end else begin
          scan_idx_nxt = adv_idx;
          scan_row_nxt = adv_row;
          scan_col_nxt = adv_col;
          state_nxt    = S_T_SELF;
        end
      end
      S_T_NB: begin
        rank_ctl.acc = nb_pend_r;
        if (nb_k_r == NB_END) begin
          state_nxt = S_T_CMP;
        end else begin
          mem_re      = nb_exists;
          mem_raddr   = nb_addr;
          nb_pend_nxt = nb_exists;
          nb_k_nxt    = nb_sel_t'(nb_k_r + 3'd1);
        end
      end
      S_T_CMP: begin
        rank_ctl.cmp = 1'b1;
        if (rank_take) begin
          best_row_nxt = scan_row_r;
          best_col_nxt = scan_col_r;
        end
        if (last_cell) begin
          state_nxt = S_DONE;
        end else begin
          scan_idx_nxt = adv_idx;
          scan_row_nxt = adv_row;
          scan_col_nxt = adv_col;
          state_nxt    = S_T_SELF;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = OIDX_W'(best_row_r);
          out_col_nxt   = OIDX_W'(best_col_r);
          out_score_nxt = max_r;
          out_ties_nxt  = TIE_W'(ties_r);
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // configuration writes restart loading
    if (cfg_we) begin
      load_cnt_nxt = '0;
      case (cfg_addr)
        CFG_NUM_GAMMA: num_gamma_nxt = cfg_wdata;
        CFG_NUM_C:     num_c_nxt     = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      num_gamma_r <= NUM_GAMMA_RST;
      num_c_r     <= NUM_C_RST;
      load_cnt_r  <= '0;
      mx_v_r      <= 1'b0;
      nb_pend_r   <= 1'b0;
      nb_k_r      <= NB_UP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_gamma_r <= num_gamma_nxt;
      num_c_r     <= num_c_nxt;
      load_cnt_r  <= load_cnt_nxt;
      mx_v_r      <= mx_v_nxt;
      nb_pend_r   <= nb_pend_nxt;
      nb_k_r      <= nb_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_idx_r  <= scan_idx_nxt;
    scan_row_r  <= scan_row_nxt;
    scan_col_r  <= scan_col_nxt;
    mx_row_r    <= mx_row_nxt;
    mx_col_r    <= mx_col_nxt;
    max_r       <= max_nxt;
    ties_r      <= ties_nxt;
    best_row_r  <= best_row_nxt;
    best_col_r  <= best_col_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_score_r <= out_score_nxt;
    out_ties_r  <= out_ties_nxt;
  end

  // result register
  assign out_chan.valid      = out_valid_r;
  assign out_chan.best_row   = out_row_r;
  assign out_chan.best_col   = out_col_r;
  assign out_chan.best_score = out_score_r;
  assign out_chan.tie_count  = out_ties_r;

  gbc_grid_mem #(
    .DEPTH (CELLS),
    .AW    (IDX_W),
    .DW    (SCORE_W)
  ) u_grid_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ld_addr[IDX_W-1:0]),
    .wdata (sat_score),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  gbc_rank u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rank_ctl),
    .rd_data (rd_data),
    .take    (rank_take)
  );

endmodule
`default_nettype wire

// ----- rtl/gbc_checker.sv -----
`default_nettype none
module gbc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [gbc_pkg::OIDX_W-1:0]    out_best_row,
  input wire logic [gbc_pkg::OIDX_W-1:0]    out_best_col,
  input wire logic [gbc_pkg::SCORE_W-1:0]   out_best_score,
  input wire logic [gbc_pkg::TIE_W-1:0]     out_tie_count
);
  import gbc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_row) &&
      $stable(out_best_col) && $stable(out_best_score) && $stable(out_tie_count))
    else $error("result changed while stalled");

  // reported maximum never exceeds one after saturation
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_score <= SCORE_ONE)
    else $error("best score above one");

  // a result needs a scan after the last cell, never straight after a transaction
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised right after an input transaction");

  // input side is closed while the grid is being scanned
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without a scan phase");

endmodule

bind grid_best_cell_with_neighbor_tiebreak gbc_checker u_gbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_best_row   (out_chan.best_row),
  .out_best_col   (out_chan.best_col),
  .out_best_score (out_chan.best_score),
  .out_tie_count  (out_chan.tie_count)
);
`default_nettype wire

// ----- test/tb_grid_best_cell_with_neighbor_tiebreak.sv -----
`timescale 1ns / 100ps
module tb_grid_best_cell_with_neighbor_tiebreak;
  import gbc_pkg::*;

  localparam int MAX_ROWS      = 16;
  localparam int MAX_COLS      = 16;
  localparam int MAX_CELLS     = MAX_ROWS * MAX_COLS;
  localparam int RANDOM_CELLS  = 1450;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_SETTLE    = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_BUDGET  = 150;
  localparam int DIRECTED_ROWS = 31;

  typedef struct packed {
    logic [OIDX_W-1:0]  best_row;
    logic [OIDX_W-1:0]  best_col;
    logic [SCORE_W-1:0] best_score;
    logic [TIE_W-1:0]   tie_count;
  } grid_result_t;

  typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [SCORE_W-1:0]    value;
    logic                  typed;
    grid_result_t          want;
  } stim_row_t;

  typedef enum int {STYLE_WIDE, STYLE_FEW, STYLE_TOP, STYLE_FLAT, STYLE_NEAR} score_style_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [SIZE_W-1:0]    cfg_wdata;

  gbc_in_if  in_chan ();
  gbc_out_if out_chan ();

  grid_best_cell_with_neighbor_tiebreak dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state: stored grid, fill position and size registers
  logic [SCORE_W-1:0] grid_mem [MAX_CELLS];
  int unsigned        fill_pos;
  logic [SIZE_W-1:0]  mdl_rows;
  logic [SIZE_W-1:0]  mdl_cols;

  grid_result_t awaited_winners [$];
  int unsigned  mismatches;
  int unsigned  cells_accepted;
  int unsigned  winners_seen;
  int unsigned  size_writes;
  int unsigned  sender_idle_pct;
  int unsigned  receiver_stall_pct;

  // directed transactions; a typed result is the one expected from that cell
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_CFG,  CFG_NUM_GAMMA, 17'd1,      1'b0, '0},
    '{ROW_CFG,  CFG_NUM_C,     17'd1,      1'b0, '0},
    '{ROW_CELL, '0,            17'd65536,  1'b1, '{4'd0, 4'd0, 17'd65536, 9'd1}},
    '{ROW_CELL, '0,            17'h1FFFF,  1'b1, '{4'd0, 4'd0, 17'd65536, 9'd1}},
    '{ROW_CELL, '0,            17'd0,      1'b1, '{4'd0, 4'd0, 17'd0, 9'd1}},
    '{ROW_CELL, '0,            17'd65537,  1'b1, '{4'd0, 4'd0, 17'd65536, 9'd1}},
    '{ROW_CFG,  CFG_NUM_GAMMA, 17'd0,      1'b0, '0},
    '{ROW_CFG,  CFG_NUM_C,     17'd0,      1'b0, '0},
    '{ROW_CELL, '0,            17'd5,      1'b1, '{4'd0, 4'd0, 17'd5, 9'd1}},
    '{ROW_CFG,  CFG_NUM_GAMMA, 17'd2,      1'b0, '0},
    '{ROW_CFG,  CFG_NUM_C,     17'd2,      1'b0, '0},
    '{ROW_CELL, '0,            17'd0,      1'b0, '0},
    '{ROW_CELL, '0,            17'd0,      1'b0, '0},
    '{ROW_CELL, '0,            17'd0,      1'b0, '0},
    '{ROW_CELL, '0,            17'd0,      1'b1, '{4'd1, 4'd1, 17'd0, 9'd4}},
    '{ROW_CELL, '0,            17'd1,      1'b0, '0},
    '{ROW_CELL, '0,            17'd9,      1'b0, '0},
    '{ROW_CELL, '0,            17'd3,      1'b0, '0},
    '{ROW_CELL, '0,            17'd2,      1'b1, '{4'd0, 4'd1, 17'd9, 9'd1}},
    '{ROW_CELL, '0,            17'd65536,  1'b0, '0},
    '{ROW_CELL, '0,            17'd65536,  1'b0, '0},
    '{ROW_CFG,  CFG_NUM_C,     17'd2,      1'b0, '0},
    '{ROW_CELL, '0,            17'd3,      1'b0, '0},
    '{ROW_CELL, '0,            17'd3,      1'b0, '0},
    '{ROW_CELL, '0,            17'd3,      1'b0, '0},
    '{ROW_CELL, '0,            17'd3,      1'b1, '{4'd1, 4'd1, 17'd3, 9'd4}},
    '{ROW_CFG,  CFG_NUM_GAMMA, 17'd1,      1'b0, '0},
    '{ROW_CFG,  CFG_NUM_C,     17'd3,      1'b0, '0},
    '{ROW_CELL, '0,            17'd7,      1'b0, '0},
    '{ROW_CELL, '0,            17'd7,      1'b0, '0},
    '{ROW_CELL, '0,            17'd7,      1'b1, '{4'd0, 4'd1, 17'd7, 9'd3}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             awaited_winners.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // append a winner to the tail of the awaited list
  task automatic queue_winner(input grid_result_t w);
    awaited_winners.insert(awaited_winners.size(), w);
  endtask

  // store one cell; after the last cell of a grid work out the winning cell
  task automatic pick_best_cell(input logic [SCORE_W-1:0] raw, output bit finished,
                                output grid_result_t winner);
    int unsigned        rows, cols, total, ties, best, r, c;
    int unsigned        cur_sum, cur_cnt, lead_sum, lead_cnt;
    longint unsigned    lhs, rhs;
    logic [SCORE_W-1:0] top;
    bit                 have;
    rows = clamp_size(mdl_rows, MAX_ROWS);
    cols = clamp_size(mdl_cols, MAX_COLS);
    total = rows * cols;
    finished = 1'b0;
    winner = '0;
    if (fill_pos >= total) fill_pos = 0;
    grid_mem[fill_pos] = (raw > SCORE_ONE) ? SCORE_ONE : raw;
    fill_pos++;
    if (fill_pos < total) return;
    fill_pos = 0;
    // highest score and how many cells share it
    top = '0;
    best = 0;
    ties = 0;
    for (int i = 0; i < total; i++) begin
      if (grid_mem[i] > top) begin
        top = grid_mem[i];
        ties = 1;
        best = i;
      end else if (grid_mem[i] == top) begin
        ties++;
      end
    end
    // rank tied cells by neighbour mean, then neighbour count, then the later cell in scan order
    if (ties > 1) begin
      have = 1'b0;
      lead_sum = 0;
      lead_cnt = 0;
      for (int i = 0; i < total; i++) begin
        if (grid_mem[i] != top) continue;
        r = i / cols;
        c = i % cols;
        cur_sum = 0;
        cur_cnt = 0;
        if (r > 0) begin cur_sum += grid_mem[i - cols]; cur_cnt++; end
        if (r + 1 < rows) begin cur_sum += grid_mem[i + cols]; cur_cnt++; end
        if (c > 0) begin cur_sum += grid_mem[i - 1]; cur_cnt++; end
        if (c + 1 < cols) begin cur_sum += grid_mem[i + 1]; cur_cnt++; end
        lhs = longint'(cur_sum) * lead_cnt;
        rhs = longint'(lead_sum) * cur_cnt;
        if (!have || lhs > rhs || (lhs == rhs && cur_cnt >= lead_cnt)) begin
          have = 1'b1;
          best = i;
          lead_sum = cur_sum;
          lead_cnt = cur_cnt;
        end
      end
    end
    finished = 1'b1;
    winner.best_row = OIDX_W'(best / cols);
    winner.best_col = OIDX_W'(best % cols);
    winner.best_score = top;
    winner.tie_count = TIE_W'(ties);
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // one input transaction, entered and left at a falling edge
  task automatic send_score(input logic [SCORE_W-1:0] s, input bit use_typed,
                            input grid_result_t typed_want);
    bit           got;
    grid_result_t w;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.score <= s;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pick_best_cell(s, got, w);
    if (use_typed) queue_winner(typed_want);
    else if (got) queue_winner(w);
    cells_accepted++;
    @(negedge clk);
  endtask

  // write enable is left high; the caller lowers it after the last write
  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == CFG_NUM_GAMMA) mdl_rows = val;
    else if (idx == CFG_NUM_C) mdl_cols = val;
    fill_pos = 0;
    size_writes++;
    @(negedge clk);
  endtask

  // stop sending, wait for every awaited result, then let the block settle
  task automatic settle_idle(input int unsigned extra);
    in_chan.valid <= 1'b0;
    while (awaited_winners.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] draw_size();
    int unsigned roll = $urandom_range(99);
    if (roll < 75) return SIZE_W'($urandom_range(1, 4));
    if (roll < 90) return SIZE_W'($urandom_range(5, 16));
    if ($urandom_range(1) == 0) return '0;
    return SIZE_W'($urandom_range(17, 31));
  endfunction

  function automatic logic [SCORE_W-1:0] draw_score(input score_style_t style,
                                                    input logic [SCORE_W-1:0] base);
    case (style)
      STYLE_WIDE: return SCORE_W'($urandom_range(0, 17'h1FFFF));
      STYLE_FEW:  return SCORE_W'($urandom_range(0, 3));
      STYLE_TOP: begin
        case ($urandom_range(3))
          0:       return SCORE_ONE;
          1:       return 17'h1FFFF;
          2:       return SCORE_W'(SCORE_ONE + $urandom_range(1, 65535));
          default: return SCORE_W'($urandom_range(0, SCORE_ONE));
        endcase
      end
      STYLE_FLAT: return base;
      default:    return SCORE_W'(base - $urandom_range(0, 2));
    endcase
  endfunction

  // result side: random stalls, changed at the falling edge
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // compare each result transaction with the oldest awaited winner
  always @(posedge clk) begin : check_winner
    grid_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      winners_seen++;
      if (awaited_winners.size() == 0) begin
        flag_mismatch($sformatf("result row %0d col %0d with none awaited",
                                out_chan.best_row, out_chan.best_col));
      end else begin
        want = awaited_winners.pop_front();
        if (out_chan.best_row !== want.best_row)
          flag_mismatch($sformatf("best_row %0d, expected %0d",
                                  out_chan.best_row, want.best_row));
        if (out_chan.best_col !== want.best_col)
          flag_mismatch($sformatf("best_col %0d, expected %0d",
                                  out_chan.best_col, want.best_col));
        if (out_chan.best_score !== want.best_score)
          flag_mismatch($sformatf("best_score %0d, expected %0d",
                                  out_chan.best_score, want.best_score));
        if (out_chan.tie_count !== want.tie_count)
          flag_mismatch($sformatf("tie_count %0d, expected %0d",
                                  out_chan.tie_count, want.tie_count));
      end
    end
  end

  // main sequence
  initial begin : stimulus
    int unsigned       phase_no, total, grids, random_start, pick;
    logic [SIZE_W-1:0] g_size, c_size;
    logic [SCORE_W-1:0] base;
    score_style_t      style;
    idle_mode_t        mode;
    bit                prev_cfg;

    mismatches = 0;
    cells_accepted = 0;
    winners_seen = 0;
    size_writes = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.score <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    mdl_rows = NUM_GAMMA_RST;
    mdl_cols = NUM_C_RST;
    fill_pos = 0;

    // directed table
    prev_cfg = 1'b0;
    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_CFG) begin
        if (!prev_cfg) settle_idle(SETTLE_CYCLES);
        write_size(directed_rows[n].reg_idx, directed_rows[n].value[SIZE_W-1:0]);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_we <= 1'b0;
        send_score(directed_rows[n].value, directed_rows[n].typed, directed_rows[n].want);
        prev_cfg = 1'b0;
      end
    end

    // random phases: new sizes while idle, then whole grids and now and then a cut-off one
    phase_no = 0;
    random_start = cells_accepted;
    while (cells_accepted - random_start < RANDOM_CELLS) begin
      settle_idle(SETTLE_CYCLES);
      mode = idle_mode_t'(phase_no % 4);
      case (mode)
        IDLE_SENDER:   begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
        IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
        IDLE_BOTH:     begin sender_idle_pct = 16; receiver_stall_pct = 16; end
        default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
      // the first phases force the size extremes
      case (phase_no)
        1: begin g_size = 5'd31; c_size = 5'd16; end
        2: begin g_size = 5'd0;  c_size = 5'd16; end
        3: begin g_size = 5'd16; c_size = 5'd1;  end
        default: begin g_size = draw_size(); c_size = draw_size(); end
      endcase
      pick = (phase_no < 4) ? 2 : $urandom_range(3);
      if (pick != 0) write_size(CFG_NUM_GAMMA, g_size);
      if (pick != 1) write_size(CFG_NUM_C, c_size);
      cfg_we <= 1'b0;
      total = clamp_size(mdl_rows, MAX_ROWS) * clamp_size(mdl_cols, MAX_COLS);
      grids = PHASE_BUDGET / total;
      if (grids < 1) grids = 1;
      if (grids > 8) grids = 8;
      base = SCORE_W'($urandom_range(0, SCORE_ONE));
      repeat (grids) begin
        style = score_style_t'($urandom_range(4));
        base = SCORE_W'($urandom_range(0, SCORE_ONE));
        for (int k = 0; k < total; k++) send_score(draw_score(style, base), 1'b0, '0);
      end
      // partial grid, thrown away by the next size write
      if (total > 1 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, total - 1))
          send_score(draw_score(STYLE_WIDE, base), 1'b0, '0);
      end
      phase_no++;
    end

    settle_idle(END_SETTLE);
    $display("run covered %0d cells (%0d random) over %0d phases and %0d size writes",
             cells_accepted, cells_accepted - random_start, phase_no, size_writes);
    $display("%0d grid winners checked, %0d mismatches", winners_seen, mismatches);
    if (mismatches == 0 && awaited_winners.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
